@@ src/sps_pkg.sv @@
// shared types and constants for the stroke point smoother
// codes for item modes, register indexes, sequencer states and the config struct
// no dependencies
package sps_pkg;

    localparam int MODE_W     = 2;
    localparam int WLEN_W     = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic              SMOOTH_RESET = 1'b1;
    localparam logic [WLEN_W-1:0] WLEN_RESET   = 4'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_PEN_DOWN = 2'd0,
        MODE_SAMPLE   = 2'd1,
        MODE_PEN_UP   = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic {
        REG_SMOOTH = 1'b0,
        REG_WLEN   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP_RD,
        S_DROP_SUB,
        S_PUSH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    // what the shared drop and mean steps are doing for the current item
    typedef enum logic [1:0] {
        CTX_PRE,
        CTX_POST,
        CTX_DRAIN
    } ctx_t;

    typedef struct packed {
        logic              smooth_en;
        logic [WLEN_W-1:0] wlen;
    } cfg_t;

endpackage

@@ src/sps_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module sps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/sps_regs.sv @@
// apb configuration registers: smoothing enable and window length
// depends on sps_pkg
module sps_regs import sps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic              smooth_reg;
    logic [WLEN_W-1:0] wlen_reg;
    logic              wr_en;
    reg_idx_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_idx_t'(paddr[REG_SEL_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= SMOOTH_RESET;
            wlen_reg   <= WLEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_SMOOTH: smooth_reg <= pwdata[0];
                REG_WLEN:   wlen_reg   <= pwdata[WLEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_SMOOTH: prdata = APB_DATA_W'(smooth_reg);
            REG_WLEN:   prdata = APB_DATA_W'(wlen_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.smooth_en = smooth_reg;
    assign cfg.wlen      = wlen_reg;

endmodule

@@ src/sps_div.sv @@
// bit-serial restoring divider, two lanes sharing one divisor
// one quotient bit per lane each cycle; depends on sps_pkg
module sps_div import sps_pkg::*; #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 5,
    parameter int Q_W   = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo_x,
    output logic [Q_W-1:0]   quo_y
);

    localparam int CYC_W = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CYC_W-1:0] cyc_reg, cyc_next;
    logic [NUM_W-1:0] q_reg [2];
    logic [NUM_W-1:0] q_next [2];
    logic [DEN_W-1:0] rem_reg [2];
    logic [DEN_W-1:0] rem_next [2];
    logic [DEN_W:0]   trial [2];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cyc_next  = cyc_reg;
        for (int i = 0; i < 2; i++)
        begin
            q_next[i]   = q_reg[i];
            rem_next[i] = rem_reg[i];
            trial[i]    = {rem_reg[i], q_reg[i][NUM_W-1]};
        end
        if (start)
        begin
            run_next  = 1'b1;
            cyc_next  = CYC_W'(NUM_W);
            q_next[0] = num_x;
            q_next[1] = num_y;
            rem_next[0] = '0;
            rem_next[1] = '0;
        end
        else if (run_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (trial[i] >= {1'b0, den})
                begin
                    rem_next[i] = DEN_W'(trial[i] - {1'b0, den});
                    q_next[i]   = {q_reg[i][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = trial[i][DEN_W-1:0];
                    q_next[i]   = {q_reg[i][NUM_W-2:0], 1'b0};
                end
            end
            cyc_next = cyc_reg - CYC_W'(1);
            if (cyc_reg == CYC_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cyc_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cyc_reg  <= cyc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            q_reg[i]   <= q_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    assign done  = done_reg;
    assign quo_x = q_reg[0][Q_W-1:0];
    assign quo_y = q_reg[1][Q_W-1:0];

endmodule

@@ src/stroke_point_smoother.sv @@
// stroke point smoother: windowed mean of pen samples, one segment item per emitted point.
// NUM_W = COORD_BITS+FRAC_BITS+clog2(WINDOW_DEPTH+1) is the divider numerator width. a smoothed
// sample is pushed and divided, with the oldest sample dropped first when the window is full,
// and its result loaded from the emit state; input is ready in the cycle after that load.
// pen up drains the window, emitting a mean and dropping the oldest sample until it is empty;
// a raw sample loads from the emit state; a stalled result holds the sequencer. reset clears
// counters, sums, previous point, returns config to defaults; the sample ram is not cleared,
// only written entries are read. depends on sps_pkg, sps_ram, sps_div, sps_regs
module stroke_point_smoother import sps_pkg::*; #(
    parameter int WINDOW_DEPTH = 16,
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 8,
    localparam int FIX_W       = COORD_BITS + FRAC_BITS,
    localparam int IN_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((4 * FIX_W + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // from_x, from_y, to_x, to_y
    output logic [0:0]            m_axis_tuser,   // segment_valid
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = COORD_BITS + CNT_W;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int SLOT_W = CNT_W + 1;
    localparam int CMP_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int RAM_W  = 2 * COORD_BITS;

    cfg_t cfg;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [SUM_W-1:0]      sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [FIX_W-1:0]      prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic                  have_prev_reg, have_prev_next;
    logic                  pen_down_reg, pen_down_next;
    logic [FIX_W-1:0]      mean_x_reg, mean_x_next, mean_y_reg, mean_y_next;
    logic [COORD_BITS-1:0] x_hold_reg, x_hold_next, y_hold_reg, y_hold_next;
    logic                  out_valid_reg, out_valid_next;
    logic [4*FIX_W-1:0]    out_data_reg, out_data_next;
    logic                  out_seg_reg, out_seg_next;
    logic                  out_last_reg, out_last_next;

    mode_t                 mode;
    logic [COORD_BITS-1:0] pos_x, pos_y;
    logic                  in_acc, out_free, dup, full, over, last_in_win;
    logic                  emit_load, ram_we, ram_re, div_start, div_done;
    logic [SLOT_W-1:0]     slot_sum, slot;
    logic [IDX_W-1:0]      ram_waddr, head_inc;
    logic [RAM_W-1:0]      ram_rdata;
    logic [FIX_W-1:0]      quo_x, quo_y, from_x, from_y;
    logic [COORD_BITS-1:0] old_x, old_y;

    sps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({y_hold_reg, x_hold_reg}),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    sps_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W),
        .Q_W   (FIX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (NUM_W'(sum_x_reg) << FRAC_BITS),
        .num_y (NUM_W'(sum_y_reg) << FRAC_BITS),
        .den   (count_reg),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    assign mode  = mode_t'(s_axis_tuser);
    assign pos_x = s_axis_tdata[COORD_BITS-1:0];
    assign pos_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign dup           = have_prev_reg && (mean_x_reg == prev_x_reg)
                           && (mean_y_reg == prev_y_reg);
    assign full          = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign over          = CMP_W'(count_reg) > CMP_W'(cfg.wlen);
    assign last_in_win   = (count_reg == CNT_W'(1));

    // circular slot after the newest sample
    assign slot_sum  = SLOT_W'(head_reg) + SLOT_W'(count_reg);
    assign slot      = (slot_sum >= SLOT_W'(WINDOW_DEPTH)) ?
                       slot_sum - SLOT_W'(WINDOW_DEPTH) : slot_sum;
    assign ram_waddr = slot[IDX_W-1:0];
    assign head_inc  = (head_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    assign old_x  = ram_rdata[COORD_BITS-1:0];
    assign old_y  = ram_rdata[RAM_W-1:COORD_BITS];
    assign from_x = have_prev_reg ? prev_x_reg : '0;
    assign from_y = have_prev_reg ? prev_y_reg : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (mode)
                        MODE_SAMPLE:
                        begin
                            if (!pen_down_reg)
                                state_next = S_IDLE;
                            else if (!cfg.smooth_en)
                                state_next = S_EMIT;
                            else if (full)
                                state_next = S_DROP_RD;
                            else
                                state_next = S_PUSH;
                        end
                        MODE_PEN_UP:
                        begin
                            if (cfg.smooth_en && (count_reg != '0))
                                state_next = S_DIV_GO;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_DROP_RD:  state_next = S_DROP_SUB;
            S_DROP_SUB:
            begin
                unique case (ctx_reg)
                    CTX_PRE:   state_next = S_PUSH;
                    CTX_POST:  state_next = S_EMIT;
                    CTX_DRAIN: state_next = last_in_win ? S_IDLE : S_DIV_GO;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_PUSH:     state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ((ctx_reg == CTX_POST) && over) ? S_DROP_RD : S_EMIT;
            end
            S_EMIT:
            begin
                if ((ctx_reg != CTX_DRAIN) && dup)
                    state_next = S_IDLE;
                else if (out_free)
                    state_next = (ctx_reg == CTX_DRAIN) ? S_DROP_RD : S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ram_re    = (state_reg == S_DROP_RD);
        ram_we    = (state_reg == S_PUSH);
        div_start = (state_reg == S_DIV_GO);
        emit_load = (state_reg == S_EMIT) && out_free
                    && !((ctx_reg != CTX_DRAIN) && dup);
    end

    // datapath
    always_comb
    begin
        ctx_next       = ctx_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        pen_down_next  = pen_down_reg;
        mean_x_next    = mean_x_reg;
        mean_y_next    = mean_y_reg;
        x_hold_next    = x_hold_reg;
        y_hold_next    = y_hold_reg;
        out_data_next  = out_data_reg;
        out_seg_next   = out_seg_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;

        if (in_acc)
        begin
            x_hold_next = pos_x;
            y_hold_next = pos_y;
            mean_x_next = FIX_W'(pos_x) << FRAC_BITS;
            mean_y_next = FIX_W'(pos_y) << FRAC_BITS;
            unique case (mode)
                MODE_PEN_DOWN:
                begin
                    pen_down_next = 1'b1;
                end
                MODE_SAMPLE:
                begin
                    ctx_next = (cfg.smooth_en && full) ? CTX_PRE : CTX_POST;
                end
                MODE_PEN_UP:
                begin
                    ctx_next = CTX_DRAIN;
                    if (!(cfg.smooth_en && (count_reg != '0)))
                    begin
                        prev_x_next    = '0;
                        prev_y_next    = '0;
                        have_prev_next = 1'b0;
                        pen_down_next  = 1'b0;
                    end
                end
                MODE_CLEAR:
                begin
                    count_next     = '0;
                    head_next      = '0;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    have_prev_next = 1'b0;
                    pen_down_next  = 1'b0;
                end
                default: ;
            endcase
        end

        if (state_reg == S_DROP_SUB)
        begin
            sum_x_next = sum_x_reg - SUM_W'(old_x);
            sum_y_next = sum_y_reg - SUM_W'(old_y);
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
            if (ctx_reg == CTX_PRE)
                ctx_next = CTX_POST;
            // end of stroke once the drain empties the window
            if ((ctx_reg == CTX_DRAIN) && last_in_win)
            begin
                prev_x_next    = '0;
                prev_y_next    = '0;
                have_prev_next = 1'b0;
                pen_down_next  = 1'b0;
            end
        end

        if (state_reg == S_PUSH)
        begin
            sum_x_next = sum_x_reg + SUM_W'(x_hold_reg);
            sum_y_next = sum_y_reg + SUM_W'(y_hold_reg);
            count_next = count_reg + CNT_W'(1);
        end

        if ((state_reg == S_DIV_WAIT) && div_done)
        begin
            mean_x_next = quo_x;
            mean_y_next = quo_y;
        end

        if (emit_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {mean_y_reg, mean_x_reg, from_y, from_x};
            out_seg_next   = have_prev_reg;
            out_last_next  = (ctx_reg != CTX_DRAIN) || last_in_win;
            prev_x_next    = mean_x_reg;
            prev_y_next    = mean_y_reg;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctx_reg       <= CTX_POST;
            count_reg     <= '0;
            head_reg      <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            pen_down_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
            pen_down_reg  <= pen_down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_x_reg   <= mean_x_next;
        mean_y_reg   <= mean_y_next;
        x_hold_reg   <= x_hold_next;
        y_hold_reg   <= y_hold_next;
        out_data_reg <= out_data_next;
        out_seg_reg  <= out_seg_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_DATA_W'(out_data_reg);
    assign m_axis_tuser[0] = out_seg_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule
